// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both assume a clock named clk and an
// active-low asynchronous reset named arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/tftpw_pkg.sv =====
`default_nettype none

package tftpw_pkg;

	// Item kinds carried in the op field.
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_PACKET = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	// Error kinds reported with send_error.
	localparam logic [1:0] ERR_SHORT     = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
	localparam logic [1:0] ERR_DISK_FULL = 2'd2;
	localparam logic [1:0] ERR_RETRY_MAX = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_MAX_RETRIES   = 1'b0;
	localparam logic CFG_TIMEOUT_TICKS = 1'b1;

	// Register reset values.
	localparam logic [3:0]  MAX_RETRIES_RST   = 4'd3;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd10000;

	// Protocol constants.
	localparam logic [15:0] OPC_DATA  = 16'd3;
	localparam logic [15:0] HDR_BYTES = 16'd4;
	localparam logic [3:0]  RETRY_SAT = 4'd15;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] packet_len;
		logic [15:0] pkt_opcode;
		logic [15:0] block_number;
		logic        store_failed;
	} item_t;

	typedef struct packed {
		logic        send_ack;
		logic [15:0] ack_block;
		logic        send_error;
		logic [1:0]  error_kind;
		logic [9:0]  commit_len;
		logic        session_end;
		logic [31:0] bytes_total;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/tftp_write_session_receiver.sv =====
// TFTP write-session receiver.
// Input channel (in_valid/in_ready) carries one word per event: a session
// start, a received packet header with its length and the sink's write status,
// or a timer tick. Every input word yields exactly one result word on the
// output channel (out_valid/out_ready): ACK and ERROR requests, the bytes
// committed by this word, a session-end flag and the running byte total.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) sets max_retries
// (index 0, low 4 bits) and timeout_ticks (index 1, 16 bits); cfg_ready is
// always high and writes are expected only while the block is idle.
// Flow: a word accepted into the input register has its result loaded into
// the output register once that register can take it. Throughput is one word
// per cycle while the output is not stalled: an input register feeds a single
// decision step that updates the session state and loads the output register.
// When out_ready is low the result holds; the input register still takes one
// more word, and in_ready drops only once both registers are full.
// Reset clears the session (idle, counters zero), empties both registers and
// restores max_retries to 3 and timeout_ticks to 10000.
`default_nettype none
`include "assert_macros.svh"

module tftp_write_session_receiver #(
	parameter int BLOCK_BYTES = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [15:0] packet_len,
	input  wire logic [15:0] pkt_opcode,
	input  wire logic [15:0] block_number,
	input  wire logic        store_failed,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             send_ack,
	output logic [15:0]      ack_block,
	output logic             send_error,
	output logic [1:0]       error_kind,
	output logic [9:0]       commit_len,
	output logic             session_end,
	output logic [31:0]      bytes_total
);

	logic [3:0]         max_retries_q;
	logic [15:0]        timeout_ticks_q;
	logic               valid_s1;
	tftpw_pkg::item_t   item_s1;
	logic               out_valid_q;
	tftpw_pkg::result_t res_q;
	tftpw_pkg::result_t res_d;
	logic               fire;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_retries_q   <= tftpw_pkg::MAX_RETRIES_RST;
			timeout_ticks_q <= tftpw_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				tftpw_pkg::CFG_MAX_RETRIES:   max_retries_q   <= cfg_data[3:0];
				tftpw_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Handshake: the decision step runs when the output register can take a word.
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op           <= op;
			item_s1.packet_len   <= packet_len;
			item_s1.pkt_opcode   <= pkt_opcode;
			item_s1.block_number <= block_number;
			item_s1.store_failed <= store_failed;
		end
	end

	tftpw_engine #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.item         (item_s1),
		.max_retries  (max_retries_q),
		.timeout_ticks(timeout_ticks_q),
		.result       (res_d)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign send_ack    = res_q.send_ack;
	assign ack_block   = res_q.ack_block;
	assign send_error  = res_q.send_error;
	assign error_kind  = res_q.error_kind;
	assign commit_len  = res_q.commit_len;
	assign session_end = res_q.session_end;
	assign bytes_total = res_q.bytes_total;

	// Every error closes the session.
	`ASSERT_IMPLIES(a_err_ends, out_valid_q && res_q.send_error, res_q.session_end, "error without session end")
	// ACK and ERROR are never requested together.
	`ASSERT_ALWAYS(a_ack_xor_err, !(out_valid_q && res_q.send_ack && res_q.send_error), "ACK and ERROR together")
	// Committed bytes always come with an ACK.
	`ASSERT_IMPLIES(a_commit_ack, out_valid_q && res_q.commit_len != 10'd0, res_q.send_ack, "commit without ACK")
	// With both registers full and the output stalled, no new word enters.
	`ASSERT_IMPLIES(a_full_stall, valid_s1 && out_valid_q && !out_ready, !in_ready && !fire, "overrun while stalled")

endmodule

`default_nettype wire

// ===== rtl/core/tftpw_engine.sv =====
`default_nettype none

module tftpw_engine #(
	parameter int BLOCK_BYTES = 512
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire tftpw_pkg::item_t item,
	input  wire logic [3:0]       max_retries,
	input  wire logic [15:0]      timeout_ticks,
	output tftpw_pkg::result_t    result
);

	localparam logic [15:0] BLOCK_LEN = 16'(BLOCK_BYTES);

	logic        active_q;
	logic [15:0] last_q;
	logic [31:0] bytes_q;
	logic [3:0]  retry_q;
	logic [15:0] timeout_q;

	logic        active_d;
	logic [15:0] last_d;
	logic [31:0] bytes_d;
	logic [3:0]  retry_d;
	logic [15:0] timeout_d;

	logic [15:0] pay;
	logic [15:0] next_blk;
	logic [3:0]  retry_inc;

	assign pay       = item.packet_len - tftpw_pkg::HDR_BYTES;
	assign next_blk  = last_q + 16'd1;
	assign retry_inc = (retry_q != tftpw_pkg::RETRY_SAT) ? retry_q + 4'd1 : retry_q;

	// Decide the result and the next session state for the current word.
	always_comb begin
		active_d  = active_q;
		last_d    = last_q;
		bytes_d   = bytes_q;
		retry_d   = retry_q;
		timeout_d = timeout_q;
		result    = '0;
		case (item.op)
			tftpw_pkg::OP_START: begin
				active_d        = 1'b1;
				last_d          = '0;
				bytes_d         = '0;
				retry_d         = '0;
				timeout_d       = timeout_ticks;
				result.send_ack = 1'b1;
			end
			tftpw_pkg::OP_PACKET: begin
				if (active_q) begin
					if (item.packet_len < tftpw_pkg::HDR_BYTES) begin
						active_d           = 1'b0;
						result.send_error  = 1'b1;
						result.error_kind  = tftpw_pkg::ERR_SHORT;
						result.session_end = 1'b1;
					end else if (item.pkt_opcode != tftpw_pkg::OPC_DATA) begin
						active_d           = 1'b0;
						result.session_end = 1'b1;
					end else begin
						retry_d   = '0;
						timeout_d = timeout_ticks;
						if (item.block_number != next_blk) begin
							// Out-of-order block: repeat the last ACK.
							result.send_ack  = 1'b1;
							result.ack_block = last_q;
						end else if (pay > BLOCK_LEN) begin
							active_d           = 1'b0;
							result.send_error  = 1'b1;
							result.error_kind  = tftpw_pkg::ERR_UNKNOWN;
							result.session_end = 1'b1;
						end else if (pay != 16'd0 && item.store_failed) begin
							last_d             = item.block_number;
							active_d           = 1'b0;
							result.send_error  = 1'b1;
							result.error_kind  = tftpw_pkg::ERR_DISK_FULL;
							result.session_end = 1'b1;
						end else begin
							if (pay != 16'd0) begin
								last_d  = item.block_number;
								bytes_d = bytes_q + {16'd0, pay};
							end
							result.send_ack   = 1'b1;
							result.ack_block  = item.block_number;
							result.commit_len = pay[9:0];
							// A short block closes the transfer.
							if (pay != BLOCK_LEN) begin
								active_d           = 1'b0;
								result.session_end = 1'b1;
							end
						end
					end
				end
			end
			tftpw_pkg::OP_TICK: begin
				if (active_q) begin
					if (timeout_q > 16'd1) begin
						timeout_d = timeout_q - 16'd1;
					end else begin
						retry_d = retry_inc;
						if (retry_inc >= max_retries) begin
							active_d           = 1'b0;
							result.send_error  = 1'b1;
							result.error_kind  = tftpw_pkg::ERR_RETRY_MAX;
							result.session_end = 1'b1;
						end else begin
							timeout_d        = timeout_ticks;
							result.send_ack  = 1'b1;
							result.ack_block = last_q;
						end
					end
				end
			end
			default: begin
				// Unused op code: ignored.
			end
		endcase
		result.bytes_total = bytes_d;
	end

	// Session state advances once per processed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			last_q    <= '0;
			bytes_q   <= '0;
			retry_q   <= '0;
			timeout_q <= '0;
		end else if (fire) begin
			active_q  <= active_d;
			last_q    <= last_d;
			bytes_q   <= bytes_d;
			retry_q   <= retry_d;
			timeout_q <= timeout_d;
		end
	end

endmodule

`default_nettype wire
